FILE: src/cht_pkg.sv
// Shared types and constants for the chained hash table.
// No dependencies; imported by every module of the block.
`default_nettype none

package cht_pkg;

    localparam int KEY_W = 16;
    localparam int POS_W = 7;

    // Residue unit consumes this many key bits per cycle.
    localparam int DIGITS_PER_STEP = 4;
    localparam int MOD_STEPS       = KEY_W / DIGITS_PER_STEP;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [POS_W-1:0] pos_t;

endpackage

`default_nettype wire

FILE: src/cht_mod.sv
// Iterative key%BUCKETS unit: DIGITS_PER_STEP shift/compare/subtract steps/cycle.
// Depends on cht_pkg.
`default_nettype none

module cht_mod #(
    parameter int BUCKETS = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire cht_pkg::key_t key_in,
    output logic               done,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);
    import cht_pkg::*;

    localparam int BIW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW    = $clog2(BUCKETS + 1);
    localparam int CNT_W = $clog2(MOD_STEPS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    key_t             sh_reg, sh_next;
    logic [RW-1:0]    rem_reg, rem_next;

    logic [RW:0]      t;
    logic [RW-1:0]    r;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        r         = rem_reg;
        t         = '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MOD_STEPS);
            sh_next   = key_in;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // shift in one key bit at a time, reduce below BUCKETS
            for (int i = 0; i < DIGITS_PER_STEP; i++)
            begin
                t = {r, sh_reg[KEY_W-1-i]};
                if (t >= (RW+1)'(BUCKETS))
                begin
                    t = t - (RW+1)'(BUCKETS);
                end
                r = t[RW-1:0];
            end
            rem_next = r;
            sh_next  = sh_reg << DIGITS_PER_STEP;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign bucket = rem_reg[BIW-1:0];

endmodule

`default_nettype wire

FILE: src/cht_pool.sv
// Node pool: key and next-link memories, one write and one registered read a cycle.
// Depends on cht_pkg only for shared conventions.
`default_nettype none

module cht_pool #(
    parameter int POOL_SIZE = 64,
    parameter int KW        = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1)-1:0] wr_idx,
    input  wire logic [KW-1:0]                          wr_key,
    input  wire logic [$clog2(POOL_SIZE + 1)-1:0]       wr_link,
    input  wire logic                                   rd_en,
    input  wire logic [((POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1)-1:0] rd_idx,
    output logic [KW-1:0]                               rd_key,
    output logic [$clog2(POOL_SIZE + 1)-1:0]            rd_link
);
    import cht_pkg::*;

    localparam int LINK_W = $clog2(POOL_SIZE + 1);

    logic [KW-1:0]     key_mem  [POOL_SIZE];
    logic [LINK_W-1:0] link_mem [POOL_SIZE];
    logic [KW-1:0]     rd_key_reg;
    logic [LINK_W-1:0] rd_link_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_idx]  <= wr_key;
            link_mem[wr_idx] <= wr_link;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg  <= key_mem[rd_idx];
            rd_link_reg <= link_mem[rd_idx];
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_link = rd_link_reg;

endmodule

`default_nettype wire

FILE: src/chained_hash_table.sv
// Hash table with separate chaining over a fixed node pool: one item at a time,
// one result per item; a new item is accepted only once the last result is loaded.
// Each item goes through these steps in order: the accept, the residue steps in
// cht_mod, taking the bucket and reading its head, linking an insert or starting
// the walk, and loading the output register. The walk reads one pool node per cycle
// through the pool's single read port. A stalled result holds the block in its
// response state until the output register is free.
// Inserts past POOL_SIZE nodes are dropped with status 1. Bucket heads come out of
// reset empty; no clearing pass is run.
// Depends on cht_pkg, cht_mod and cht_pool.
`default_nettype none

module chained_hash_table #(
    parameter int BUCKETS   = 7,
    parameter int POOL_SIZE = 64,
    parameter int KEY_WIDTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          opcode,
    input  wire cht_pkg::key_t key,
    output logic               out_valid,
    input  wire logic          out_stall,
    output cht_pkg::pos_t      position,
    output logic               status
);
    import cht_pkg::*;

    localparam int KW     = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int BIW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IDX_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int LINK_W = $clog2(POOL_SIZE + 1);
    localparam key_t KEY_MASK = key_t'((33'd1 << KW) - 33'd1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              op_reg, op_next;
    key_t              key_reg, key_next;
    logic [BIW-1:0]    bucket_reg, bucket_next;
    logic [LINK_W-1:0] count_reg, count_next;
    logic [LINK_W-1:0] nodes_used_reg, nodes_used_next;
    pos_t              res_pos_reg, res_pos_next;
    logic              res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    pos_t              position_reg, position_next;
    logic              status_reg, status_next;

    logic              in_take;
    logic              mod_done;
    logic [BIW-1:0]    mod_bucket;

    // bucket head memory with per-bucket valid bits
    logic [LINK_W-1:0] head_mem [BUCKETS];
    logic [BUCKETS-1:0] head_vld_reg;
    logic [LINK_W-1:0] head_q_reg;
    logic              head_q_vld_reg;
    logic              head_rd;
    logic              head_we;
    logic [LINK_W-1:0] head_link;
    logic [LINK_W-1:0] new_link;

    logic              pool_we;
    logic              pool_re;
    logic [IDX_W-1:0]  pool_rd_idx;
    logic [LINK_W-1:0] rd_target;
    logic [LINK_W-1:0] rd_target_m1;
    logic [KW-1:0]     pool_key;
    logic [LINK_W-1:0] pool_link;
    logic              pool_full;

    assign in_take   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign head_link = head_q_vld_reg ? head_q_reg : '0;
    assign new_link  = nodes_used_reg + LINK_W'(1);
    assign pool_full = (nodes_used_reg == LINK_W'(POOL_SIZE));
    assign rd_target_m1 = rd_target - LINK_W'(1);
    assign pool_rd_idx  = rd_target_m1[IDX_W-1:0];

    cht_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_take),
        .key_in (key & KEY_MASK),
        .done   (mod_done),
        .bucket (mod_bucket)
    );

    cht_pool #(
        .POOL_SIZE (POOL_SIZE),
        .KW        (KW)
    ) u_pool (
        .clk     (clk),
        .wr_en   (pool_we),
        .wr_idx  (nodes_used_reg[IDX_W-1:0]),
        .wr_key  (key_reg[KW-1:0]),
        .wr_link (head_link),
        .rd_en   (pool_re),
        .rd_idx  (pool_rd_idx),
        .rd_key  (pool_key),
        .rd_link (pool_link)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        bucket_next     = bucket_reg;
        count_next      = count_reg;
        nodes_used_next = nodes_used_reg;
        res_pos_next    = res_pos_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        position_next   = position_reg;
        status_next     = status_reg;
        head_rd         = 1'b0;
        head_we         = 1'b0;
        pool_we         = 1'b0;
        pool_re         = 1'b0;
        rd_target       = head_link;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next    = opcode;
                    key_next   = key & KEY_MASK;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    bucket_next = mod_bucket;
                    head_rd     = 1'b1;
                    state_next  = S_HEAD;
                end
            end
            S_HEAD:
            begin
                res_pos_next    = '0;
                res_status_next = ST_OK;
                if (op_reg == OP_INSERT)
                begin
                    if (pool_full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        // link new node at the head of its chain
                        pool_we         = 1'b1;
                        head_we         = 1'b1;
                        nodes_used_next = new_link;
                    end
                    state_next = S_RESP;
                end
                else if (head_link == '0)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    pool_re    = 1'b1;
                    count_next = LINK_W'(1);
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                rd_target = pool_link;
                if (pool_key == key_reg[KW-1:0])
                begin
                    res_pos_next = pos_t'(count_reg);
                    state_next   = S_RESP;
                end
                else if (pool_link == '0 || count_reg == LINK_W'(POOL_SIZE))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    // advance to the next node
                    pool_re    = 1'b1;
                    count_next = count_reg + LINK_W'(1);
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    position_next  = res_pos_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nodes_used_reg <= '0;
            out_valid_reg  <= 1'b0;
            head_vld_reg   <= '0;
            head_q_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            out_valid_reg  <= out_valid_next;
            if (head_we)
            begin
                head_vld_reg[bucket_reg] <= 1'b1;
            end
            if (head_rd)
            begin
                head_q_vld_reg <= head_vld_reg[mod_bucket];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        bucket_reg     <= bucket_next;
        count_reg      <= count_next;
        res_pos_reg    <= res_pos_next;
        res_status_reg <= res_status_next;
        position_reg   <= position_next;
        status_reg     <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[bucket_reg] <= new_link;
        end
        if (head_rd)
        begin
            head_q_reg <= head_mem[mod_bucket];
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign status    = status_reg;

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nodes_used_reg <= LINK_W'(POOL_SIZE))
        else $error("node count exceeds pool size");

    a_accept_starts_mod: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == S_MOD)
        else $error("accepted item did not start the residue unit");

    a_insert_grows_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HEAD && op_reg == OP_INSERT && !pool_full)
        |=> nodes_used_reg == $past(nodes_used_reg) + LINK_W'(1))
        else $error("insert did not take exactly one node");

    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> count_reg != '0)
        else $error("chain walk with zero position");

    a_full_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && (!out_valid_reg || !out_stall)
         && res_status_reg == ST_FULL)
        |=> position_reg == '0)
        else $error("dropped insert reported a position");

endmodule

`default_nettype wire
